/* design/mcbd_pkg.sv */
// Shared types, constants and wheel drive functions of the motor command byte decoder.
`default_nettype none

package mcbd_pkg;

    // Period of the PWM timers; a channel at rest matches at this value.
    localparam int PWM_PERIOD = 256;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int MATCH_W = $clog2(PWM_PERIOD + 1);
    localparam int HIST_DEPTH = 3;

    // Width of the drive level arithmetic, wide enough for the period and twice a magnitude.
    localparam int CALC_W = ($clog2(PWM_PERIOD) + 2 > 10) ? $clog2(PWM_PERIOD) + 2 : 10;

    // Stream and configuration port widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = ((4 * MATCH_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_END_CODE     = 3'd0,
        REG_ENGINES_CODE = 3'd1,
        REG_SYNC_CODE    = 3'd2,
        REG_TEST_CODE    = 3'd3,
        REG_DIR_MASK     = 3'd4
    } cfg_reg_t;

    localparam logic [BYTE_W-1:0] DIR_MASK_RESET = 8'h80;

    // Match value of a channel that is not driven.
    localparam logic [MATCH_W-1:0] MATCH_FULL = MATCH_W'(PWM_PERIOD);

    // Configuration register contents.
    typedef struct packed {
        logic [BYTE_W-1:0] end_code;
        logic [BYTE_W-1:0] engines_code;
        logic [BYTE_W-1:0] sync_code;
        logic [BYTE_W-1:0] test_code;
        logic [BYTE_W-1:0] dir_mask;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic               engines_seen;
        logic               sync_request;
        logic               test_request;
        logic [MATCH_W-1:0] right_a_match;
        logic [MATCH_W-1:0] right_b_match;
        logic [MATCH_W-1:0] left_a_match;
        logic [MATCH_W-1:0] left_b_match;
    } result_t;

    // Match values of the two channels of one wheel.
    typedef struct packed {
        logic [MATCH_W-1:0] a;
        logic [MATCH_W-1:0] b;
    } wheel_t;

    // Period less twice the magnitude, saturated at zero.
    function automatic logic [MATCH_W-1:0] drive_level(input logic [BYTE_W-1:0] mag);
        logic [CALC_W-1:0] twice;
        logic [CALC_W-1:0] period;
        logic [CALC_W-1:0] diff;
        twice  = CALC_W'({mag, 1'b0});
        period = CALC_W'(PWM_PERIOD);
        diff   = (twice >= period) ? '0 : period - twice;
        return diff[MATCH_W-1:0];
    endfunction

    // Channel match values for one wheel drive byte.
    function automatic wheel_t wheel_drive(input logic [BYTE_W-1:0] w,
                                           input logic [BYTE_W-1:0] mask);
        wheel_t            res;
        logic [BYTE_W-1:0] mag;
        mag = w & ~mask;
        if ((w & mask) != '0)
        begin
            res.a = drive_level(mag);
            res.b = MATCH_FULL;
        end
        else
        begin
            res.a = MATCH_FULL;
            res.b = drive_level(mag);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/motor_command_byte_decoder.sv */
// Top level of the motor command byte decoder.
//
// Received serial bytes enter on the s_ stream, one byte per request in s_tdata.
// Every byte gives one result request on the m_ stream: m_tuser holds the
// engines, sync and test flags, and m_tdata the four PWM match values held
// after that byte, which change only when an engines command completes.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while the
// stream is idle; indexes beyond the dir_mask register are ignored.
// A taken byte has its result registered in the output register, or in the skid
// stage under back-pressure. Throughput is one byte per cycle while m_tready holds,
// set by the single pass of compare logic between byte history and output register.
// When the receiver stalls, one more byte is taken into the skid stage; then
// s_tready drops until m_tready rises again, and no request is lost.
// Reset clears the byte history, sets all match values to the PWM period,
// clears the codes, sets dir_mask to its top bit and empties the output.
`default_nettype none

module motor_command_byte_decoder
    import mcbd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [8:0] right_a_match, [17:9] right_b_match, [26:18] left_a_match,
    // [35:27] left_b_match, rest zero
    output logic [M_TDATA_W-1:0]       m_tdata,
    // [0] engines_seen, [1] sync_request, [2] test_request
    output logic [M_TUSER_W-1:0]       m_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    result_t dec_result;
    result_t out_result;
    logic    push;

    assign push = s_tvalid && s_tready;

    mcbd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mcbd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .push    (push),
        .rx_byte (s_tdata[BYTE_W-1:0]),
        .result  (dec_result)
    );

    mcbd_out_skid u_out_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .in_result  (dec_result),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // Pack the result onto the stream, first field in the lowest bits.
    assign m_tdata = M_TDATA_W'({out_result.left_b_match, out_result.left_a_match,
                                 out_result.right_b_match, out_result.right_a_match});
    assign m_tuser = {out_result.test_request, out_result.sync_request,
                      out_result.engines_seen};

endmodule

`default_nettype wire

/* design/mcbd_cfg_regs.sv */
// Configuration register file of the motor command byte decoder.
`default_nettype none

module mcbd_cfg_regs
    import mcbd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Select the register that a write addresses; other indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_END_CODE:     cfg_next.end_code     = cfg_wdata[BYTE_W-1:0];
                REG_ENGINES_CODE: cfg_next.engines_code = cfg_wdata[BYTE_W-1:0];
                REG_SYNC_CODE:    cfg_next.sync_code    = cfg_wdata[BYTE_W-1:0];
                REG_TEST_CODE:    cfg_next.test_code    = cfg_wdata[BYTE_W-1:0];
                REG_DIR_MASK:     cfg_next.dir_mask     = cfg_wdata[BYTE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.end_code     <= '0;
            cfg_reg.engines_code <= '0;
            cfg_reg.sync_code    <= '0;
            cfg_reg.test_code    <= '0;
            cfg_reg.dir_mask     <= DIR_MASK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* design/mcbd_decode.sv */
// Byte history, command matching and PWM match state of the motor command byte decoder.
`default_nettype none

module mcbd_decode
    import mcbd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              push,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output result_t                result
);

    logic [BYTE_W-1:0]  hist_reg  [HIST_DEPTH];
    logic [BYTE_W-1:0]  hist_next [HIST_DEPTH];
    logic [MATCH_W-1:0] right_a_reg, right_b_reg, left_a_reg, left_b_reg;
    logic [MATCH_W-1:0] right_a_next, right_b_next, left_a_next, left_b_next;
    logic               is_end;
    logic               eng;
    logic               syn;
    logic               tst;
    wheel_t             right_drive;
    wheel_t             left_drive;

    // Pattern matching; engines takes priority over sync, and sync over test.
    always_comb
    begin
        is_end = (rx_byte == cfg.end_code);
        eng    = is_end && (hist_reg[2] == cfg.engines_code);
        syn    = is_end && !eng && (hist_reg[0] == cfg.sync_code);
        tst    = is_end && !eng && !syn && (hist_reg[0] == cfg.test_code);
    end

    // Wheel drives: one byte back is the right wheel, two back the left.
    assign right_drive = wheel_drive(hist_reg[0], cfg.dir_mask);
    assign left_drive  = wheel_drive(hist_reg[1], cfg.dir_mask);

    // Next history and match values for the byte being taken.
    always_comb
    begin
        hist_next    = hist_reg;
        right_a_next = right_a_reg;
        right_b_next = right_b_reg;
        left_a_next  = left_a_reg;
        left_b_next  = left_b_reg;
        if (push)
        begin
            priority if (eng)
            begin
                hist_next[0] = '0;
                hist_next[1] = '0;
                hist_next[2] = '0;
                right_a_next = right_drive.a;
                right_b_next = right_drive.b;
                left_a_next  = left_drive.a;
                left_b_next  = left_drive.b;
            end
            else if (syn || tst)
            begin
                hist_next[0] = '0;
                hist_next[1] = '0;
                hist_next[2] = hist_reg[1];
            end
            else
            begin
                hist_next[0] = rx_byte;
                hist_next[1] = hist_reg[0];
                hist_next[2] = hist_reg[1];
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
            right_a_reg <= MATCH_FULL;
            right_b_reg <= MATCH_FULL;
            left_a_reg  <= MATCH_FULL;
            left_b_reg  <= MATCH_FULL;
        end
        else
        begin
            hist_reg    <= hist_next;
            right_a_reg <= right_a_next;
            right_b_reg <= right_b_next;
            left_a_reg  <= left_a_next;
            left_b_reg  <= left_b_next;
        end
    end

    // Result of the byte being taken, showing the match values held after it.
    always_comb
    begin
        result.engines_seen  = eng;
        result.sync_request  = syn;
        result.test_request  = tst;
        result.right_a_match = right_a_next;
        result.right_b_match = right_b_next;
        result.left_a_match  = left_a_next;
        result.left_b_match  = left_b_next;
    end

    // At most one command completes on a byte.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0({eng, syn, tst}))
        else $error("more than one command matched on one byte");

    // An engines command leaves the whole history cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        push && eng |=> hist_reg[0] == '0 && hist_reg[1] == '0 && hist_reg[2] == '0)
        else $error("history not cleared after engines command");

    // Sync and test clear the two newest history bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        push && (syn || tst) |=> hist_reg[0] == '0 && hist_reg[1] == '0)
        else $error("history not cleared after sync or test command");

endmodule

`default_nettype wire

/* design/mcbd_out_skid.sv */
// Output register with skid stage of the motor command byte decoder.
`default_nettype none

module mcbd_out_skid
    import mcbd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t in_result,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_result
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    advance;

    // The output register may take new data when empty or being drained.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !skid_valid_reg;

    // Move requests through the output register and the skid stage.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (advance)
        begin
            priority if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_next       = in_result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_next       = in_result;
            skid_valid_next = 1'b1;
        end
    end

    // Control flags are reset; payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // The skid stage only fills behind a full output register.
    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    // After a request is taken, the output register always holds a valid request in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) push |=> out_valid_reg)
        else $error("request lost after acceptance");

endmodule

`default_nettype wire

/* bench/tb_motor_command_byte_decoder.sv */
// Self-checking testbench for the motor command byte decoder stream block.
`timescale 1ns / 1ps

module tb_motor_command_byte_decoder;
    import mcbd_pkg::*;

    // Command bytes used by the directed part.
    localparam logic [BYTE_W-1:0] CMD_END     = 8'h0E;
    localparam logic [BYTE_W-1:0] CMD_ENGINES = 8'h04;
    localparam logic [BYTE_W-1:0] CMD_SYNC    = 8'h0C;
    localparam logic [BYTE_W-1:0] CMD_TEST    = 8'h0D;

    // An index past the last register; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG = '1;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 40;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_BYTES    = 80;

    // How the byte source spaces its requests.
    typedef enum int {PACE_STEADY, PACE_BURSTY, PACE_SPARSE} pace_t;
    // How the result sink applies back-pressure.
    typedef enum int {DRAIN_ALWAYS, DRAIN_RANDOM, DRAIN_PATTERN} drain_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;   // [8:0] right_a, [17:9] right_b, [26:18] left_a, [35:27] left_b
    logic [M_TUSER_W-1:0]  m_tuser;   // [0] engines_seen, [1] sync_request, [2] test_request
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Bytes waiting to be sent and decoder results still to arrive.
    logic [BYTE_W-1:0] rx_stream [$];
    result_t           awaited_results [$];

    // Decoder state as the testbench sees it.
    cfg_t               model_cfg;
    logic [BYTE_W-1:0]  byte_history [HIST_DEPTH];
    logic [MATCH_W-1:0] held_matches [4];

    pace_t       sender_pace = PACE_STEADY;
    drain_t      ready_mode = DRAIN_ALWAYS;
    logic [15:0] ready_pat = 16'hFFFF;
    logic        byte_taken = 1'b0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          quiet_cycles = 0;
    int          mismatches = 0;
    int          bytes_queued = 0;
    int          bytes_taken = 0;
    int          results_checked = 0;
    int          engines_count = 0;
    int          sync_count = 0;
    int          test_count = 0;
    int          phases_run = 0;

    string field_names [7] = '{"engines_seen", "sync_request", "test_request",
                               "right_a_match", "right_b_match",
                               "left_a_match", "left_b_match"};

    motor_command_byte_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Records one mismatch; printing stops after a while but counting does not.
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Match values of the two channels for one wheel drive byte.
    function automatic wheel_t wheel_levels(input logic [BYTE_W-1:0] w);
        wheel_t             lv;
        int                 twice;
        logic [MATCH_W-1:0] active;
        twice = 2 * int'(w & ~model_cfg.dir_mask);
        active = (twice >= PWM_PERIOD) ? '0 : MATCH_W'(PWM_PERIOD - twice);
        if ((w & model_cfg.dir_mask) != '0)
        begin
            lv.a = active;
            lv.b = MATCH_W'(PWM_PERIOD);
        end
        else
        begin
            lv.a = MATCH_W'(PWM_PERIOD);
            lv.b = active;
        end
        return lv;
    endfunction

    // Advances the decoder state by one received byte and returns its result.
    function automatic result_t decode_byte(input logic [BYTE_W-1:0] b);
        result_t           r;
        wheel_t            right_w;
        wheel_t            left_w;
        logic [BYTE_W-1:0] stored;
        logic [BYTE_W-1:0] keep0;
        logic [BYTE_W-1:0] keep1;
        r = '0;
        stored = b;
        keep0 = byte_history[0];
        keep1 = byte_history[1];
        if (b == model_cfg.end_code)
        begin
            // Engines takes priority, then sync, then test.
            if (byte_history[2] == model_cfg.engines_code)
            begin
                r.engines_seen = 1'b1;
                right_w = wheel_levels(byte_history[0]);
                left_w = wheel_levels(byte_history[1]);
                held_matches[0] = right_w.a;
                held_matches[1] = right_w.b;
                held_matches[2] = left_w.a;
                held_matches[3] = left_w.b;
                stored = '0;
                keep0 = '0;
                keep1 = '0;
            end
            else if (byte_history[0] == model_cfg.sync_code)
            begin
                r.sync_request = 1'b1;
                stored = '0;
                keep0 = '0;
            end
            else if (byte_history[0] == model_cfg.test_code)
            begin
                r.test_request = 1'b1;
                stored = '0;
                keep0 = '0;
            end
        end
        byte_history[2] = keep1;
        byte_history[1] = keep0;
        byte_history[0] = stored;
        r.right_a_match = held_matches[0];
        r.right_b_match = held_matches[1];
        r.left_a_match = held_matches[2];
        r.left_b_match = held_matches[3];
        return r;
    endfunction

    // Byte source: bursts of requests separated by gaps, holding a byte until it is taken.
    always @(negedge clk)
    begin
        if (!(s_tvalid && !byte_taken))
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata <= S_TDATA_W'($urandom);
                gap_left--;
            end
            else if (rx_stream.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= rx_stream[0];
                burst_left--;
                if (burst_left <= 0)
                begin
                    case (sender_pace)
                        PACE_STEADY:
                        begin
                            burst_left = 16;
                            gap_left = 0;
                        end
                        PACE_BURSTY:
                        begin
                            burst_left = $urandom_range(12, 1);
                            gap_left = $urandom_range(6, 0);
                        end
                        default:
                        begin
                            burst_left = $urandom_range(3, 1);
                            gap_left = $urandom_range(4, 1);
                        end
                    endcase
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
                s_tdata <= S_TDATA_W'($urandom);
            end
        end
    end

    // Result sink back-pressure.
    always @(negedge clk)
    begin
        case (ready_mode)
            DRAIN_ALWAYS:
                m_tready <= 1'b1;
            DRAIN_RANDOM:
                m_tready <= ($urandom_range(2, 0) != 0);
            default:
            begin
                m_tready <= ready_pat[0];
                ready_pat = {ready_pat[0], ready_pat[15:1]};
            end
        endcase
    end

    // Monitor: checks results, predicts accepted bytes, tracks writes and watches for a hang.
    always @(posedge clk)
    begin : monitor
        result_t            want;
        logic [MATCH_W-1:0] got_f [7];
        logic [MATCH_W-1:0] want_f [7];
        if (rst_n)
        begin
            byte_taken = s_tvalid && s_tready;

            // Compare an accepted result with the oldest prediction.
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result request with no byte outstanding");
                else
                begin
                    want = awaited_results.pop_front();
                    want_f = '{MATCH_W'(want.engines_seen), MATCH_W'(want.sync_request),
                               MATCH_W'(want.test_request),
                               want.right_a_match, want.right_b_match,
                               want.left_a_match, want.left_b_match};
                    for (int k = 0; k < 3; k++)
                        got_f[k] = MATCH_W'(m_tuser[k]);
                    for (int k = 0; k < 4; k++)
                        got_f[3 + k] = m_tdata[k * MATCH_W +: MATCH_W];
                    for (int k = 0; k < 7; k++)
                        if (got_f[k] !== want_f[k])
                            report_mismatch($sformatf("result %0d: %s is %0d, predicted %0d",
                                results_checked, field_names[k], got_f[k], want_f[k]));
                    results_checked++;
                    engines_count += want.engines_seen;
                    sync_count += want.sync_request;
                    test_count += want.test_request;
                end
            end

            // Predict the result of a byte taken at this edge.
            if (byte_taken)
            begin
                awaited_results.push_back(decode_byte(s_tdata));
                void'(rx_stream.pop_front());
                bytes_taken++;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_END_CODE:     model_cfg.end_code = cfg_wdata;
                    REG_ENGINES_CODE: model_cfg.engines_code = cfg_wdata;
                    REG_SYNC_CODE:    model_cfg.sync_code = cfg_wdata;
                    REG_TEST_CODE:    model_cfg.test_code = cfg_wdata;
                    REG_DIR_MASK:     model_cfg.dir_mask = cfg_wdata;
                    default:          ;
                endcase
            end

            // Watchdog on cycles without any accepted request or write.
            if (byte_taken || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        rx_stream.push_back(b);
        bytes_queued++;
    endtask

    // Waits until every byte has been taken and every result has arrived.
    task automatic settle();
        while (rx_stream.size() != 0 || awaited_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [BYTE_W-1:0] end_c, input logic [BYTE_W-1:0] eng_c,
                             input logic [BYTE_W-1:0] sync_c, input logic [BYTE_W-1:0] test_c,
                             input logic [BYTE_W-1:0] mask);
        settle();
        write_reg(REG_END_CODE, end_c);
        write_reg(REG_ENGINES_CODE, eng_c);
        write_reg(REG_SYNC_CODE, sync_c);
        write_reg(REG_TEST_CODE, test_c);
        write_reg(REG_DIR_MASK, mask);
        phases_run++;
    endtask

    // Wheel byte leaning towards the extremes of the magnitude.
    function automatic logic [BYTE_W-1:0] wheel_byte();
        case ($urandom_range(3, 0))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // Mostly well-formed commands with random content, plus broken commands and noise.
    task automatic queue_command_mix(input int count);
        int target;
        target = bytes_queued + count;
        while (bytes_queued < target)
        begin
            case ($urandom_range(9, 0))
                0, 1, 2, 3:
                begin
                    send_byte(model_cfg.engines_code);
                    send_byte(wheel_byte());
                    send_byte(wheel_byte());
                    send_byte(model_cfg.end_code);
                end
                4, 5:
                begin
                    send_byte(model_cfg.sync_code);
                    send_byte(model_cfg.end_code);
                end
                6:
                begin
                    send_byte(model_cfg.test_code);
                    send_byte(model_cfg.end_code);
                end
                7:
                begin
                    // Engines command with one wheel byte too few or too many.
                    send_byte(model_cfg.engines_code);
                    repeat ($urandom_range(1, 0) ? 1 : 3)
                        send_byte(wheel_byte());
                    send_byte(model_cfg.end_code);
                end
                default:
                begin
                    send_byte(BYTE_W'($urandom));
                    if ($urandom_range(2, 0) == 0)
                        send_byte(model_cfg.end_code);
                end
            endcase
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        logic [BYTE_W-1:0] e;
        logic [BYTE_W-1:0] g;
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] t;
        logic [BYTE_W-1:0] m;

        model_cfg = '{end_code: '0, engines_code: '0, sync_code: '0, test_code: '0,
                      dir_mask: DIR_MASK_RESET};
        byte_history = '{default: '0};
        held_matches = '{default: MATCH_W'(PWM_PERIOD)};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: every code is zero, so zero bytes complete engines commands.
        sender_pace = PACE_BURSTY;
        ready_mode = DRAIN_RANDOM;
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h5A);
        send_byte(8'h00);
        send_byte(8'h00);

        // Directed commands with the default direction bit.
        configure(CMD_END, CMD_ENGINES, CMD_SYNC, CMD_TEST, DIR_MASK_RESET);
        // Left forward at full magnitude, right forward at rest.
        send_byte(CMD_ENGINES); send_byte(8'hFF); send_byte(8'h80); send_byte(CMD_END);
        // Left backward at rest, right backward at full magnitude.
        send_byte(CMD_ENGINES); send_byte(8'h00); send_byte(8'h7F); send_byte(CMD_END);
        // Half magnitude each way.
        send_byte(CMD_ENGINES); send_byte(8'hC0); send_byte(8'h40); send_byte(CMD_END);
        send_byte(CMD_SYNC); send_byte(CMD_END);
        send_byte(CMD_TEST); send_byte(CMD_END);
        // End byte with nothing to match, then an end byte on its own.
        send_byte(8'h55); send_byte(CMD_END);
        send_byte(CMD_END);
        // Engines code four bytes back is not a command.
        send_byte(CMD_ENGINES); send_byte(8'h11); send_byte(8'h22); send_byte(8'h33);
        send_byte(CMD_END);

        // Random phases, each with its own settings and pacing.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            e = BYTE_W'($urandom);
            g = BYTE_W'($urandom);
            s = BYTE_W'($urandom);
            t = BYTE_W'($urandom);
            case (p)
                0: e = 8'h00;
                1:
                begin
                    e = 8'hFF;
                    g = 8'h00;
                end
                2:
                begin
                    s = g;
                    t = g;
                end
                3: t = s;
                4:
                begin
                    e = 8'hFF;
                    g = 8'hFF;
                    s = 8'hFF;
                    t = 8'hFF;
                end
                5:
                begin
                    // Zero codes can match history bytes cleared by an earlier command.
                    g = 8'h00;
                    s = 8'h00;
                end
                default: ;
            endcase
            case (p % 6)
                0:       m = 8'h00;
                1:       m = 8'hFF;
                2:       m = 8'h01;
                3:       m = DIR_MASK_RESET;
                4:       m = 8'h01 << $urandom_range(7, 0);
                default: m = BYTE_W'($urandom);
            endcase
            configure(e, g, s, t, m);
            if (p == 2)
                write_reg(UNUSED_REG, CFG_DATA_W'($urandom));
            sender_pace = pace_t'(p % 3);
            ready_mode = drain_t'((p + p / 3) % 3);
            ready_pat = 16'($urandom) | 16'h0001;
            queue_command_mix(PHASE_BYTES);
        end

        // Drain and allow a few more cycles for any stray result.
        settle();
        repeat (8) @(negedge clk);
        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

        $display("Decoded %0d bytes across %0d settings: %0d engines, %0d sync, %0d test commands.",
                 bytes_taken, phases_run + 1, engines_count, sync_count, test_count);
        $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
